// ----- hdl/lswc_pkg.sv -----
// Shared types, constants and helpers for the line segment window clipper.
`timescale 1ns / 1ps
package lswc_pkg;

  localparam int COORD_BITS = 12;
  localparam int DW = COORD_BITS + 1;       // coordinate difference width
  localparam int PW = 2 * DW;               // product / dividend width
  localparam int CNTW = $clog2(PW + 1);
  localparam int MAX_MOVES = 4;
  localparam int MVW = $clog2(MAX_MOVES + 1);

  localparam int OC_LEFT   = 0;
  localparam int OC_RIGHT  = 1;
  localparam int OC_BOTTOM = 2;
  localparam int OC_TOP    = 3;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    logic   visible;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIVP,
    ST_DIV,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CLS_ACCEPT,
    CLS_REJECT,
    CLS_MOVE
  } cls_t;

  typedef struct packed {
    logic load;       // take a new request
    logic setup;      // pick endpoint and edge for the next move
    logic mul;        // register the product
    logic div_init;   // load divider magnitudes
    logic div_step;   // one restoring divide step
    logic update;     // write the moved endpoint
    logic emit;       // capture the result
    logic emit_vis;   // result is visible
  } dp_cmd_t;

  typedef struct packed {
    cls_t cls;
    logic den_zero;
  } dp_sts_t;

  function automatic logic [3:0] outcode(coord_t x, coord_t y, coord_t l, coord_t r,
                                         coord_t b, coord_t t);
    logic [3:0] c;
    c = '0;
    c[OC_LEFT]   = (x < l);
    c[OC_RIGHT]  = (x > r);
    c[OC_BOTTOM] = (y < b);
    c[OC_TOP]    = (y > t);
    return c;
  endfunction

endpackage

// ----- hdl/lswc_datapath.sv -----
// Datapath: window registers, endpoints, multiplier and serial divider.
`timescale 1ns / 1ps
module lswc_datapath
  import lswc_pkg::*;
(
  input  logic         clk,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  coord_t       cfg_data,
  input  logic         rst_n,
  input  in_item_t     in_item,
  input  dp_cmd_t      cmd,
  output dp_sts_t      sts,
  output out_item_t    out_result
);

  coord_t win_l_r, win_r_r, win_b_r, win_t_r;
  coord_t x0_r, y0_r, x1_r, y1_r;
  logic   mv0_r, axis_x_r;
  coord_t a0_r, edge_r, keep_r;
  logic signed [DW-1:0] da_r, db_r, den_r;
  logic signed [PW-1:0] prod_r;
  logic [PW-1:0] dvd_r;
  logic [DW-1:0] dvs_r, rem_r;
  logic          neg_r;
  out_item_t     res_r;

  logic [3:0] c0, c1, c;
  always_comb begin
    c0 = outcode(x0_r, y0_r, win_l_r, win_r_r, win_b_r, win_t_r);
    c1 = outcode(x1_r, y1_r, win_l_r, win_r_r, win_b_r, win_t_r);
    c  = (c0 != '0) ? c0 : c1;
    if ((c0 | c1) == '0) begin
      sts.cls = CLS_ACCEPT;
    end else if ((c0 & c1) != '0) begin
      sts.cls = CLS_REJECT;
    end else begin
      sts.cls = CLS_MOVE;
    end
    sts.den_zero = (den_r == '0);
  end

  // Edge selection for the next move, in order left, right, bottom, top.
  coord_t s_a0, s_a1, s_b0, s_b1, s_edge, s_keep;
  logic   s_axis_x;
  always_comb begin
    s_axis_x = c[OC_LEFT] | c[OC_RIGHT];
    if (c[OC_LEFT]) begin
      s_edge = win_l_r;
    end else if (c[OC_RIGHT]) begin
      s_edge = win_r_r;
    end else if (c[OC_BOTTOM]) begin
      s_edge = win_b_r;
    end else begin
      s_edge = win_t_r;
    end
    if (s_axis_x) begin
      s_a0 = y0_r; s_a1 = y1_r; s_b0 = x0_r; s_b1 = x1_r;
      s_keep = (c0 != '0) ? y0_r : y1_r;
    end else begin
      s_a0 = x0_r; s_a1 = x1_r; s_b0 = y0_r; s_b1 = y1_r;
      s_keep = (c0 != '0) ? x0_r : x1_r;
    end
  end

  logic [DW-1:0] rem_sh;
  logic [DW:0]   trial;
  logic [PW-1:0] pmag;
  logic [DW-1:0] dmag;
  logic [DW:0]   q_s, sum;
  coord_t        new_c;
  always_comb begin
    pmag   = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
    dmag   = den_r[DW-1] ? DW'(-den_r) : DW'(den_r);
    rem_sh = {rem_r[DW-2:0], dvd_r[PW-1]};
    trial  = {1'b0, rem_sh} - {1'b0, dvs_r};
    q_s    = neg_r ? (DW+1)'(-dvd_r[DW:0]) : dvd_r[DW:0];
    sum    = q_s + {{2{a0_r[COORD_BITS-1]}}, a0_r};
    new_c  = sts.den_zero ? keep_r : sum[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_l_r <= COORD_BITS'(100);
      win_r_r <= COORD_BITS'(540);
      win_b_r <= COORD_BITS'(100);
      win_t_r <= COORD_BITS'(380);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEFT:   win_l_r <= cfg_data;
        REG_RIGHT:  win_r_r <= cfg_data;
        REG_BOTTOM: win_b_r <= cfg_data;
        REG_TOP:    win_t_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r <= in_item.start_x;
      y0_r <= in_item.start_y;
      x1_r <= in_item.end_x;
      y1_r <= in_item.end_y;
    end
    if (cmd.setup) begin
      mv0_r    <= (c0 != '0);
      axis_x_r <= s_axis_x;
      a0_r     <= s_a0;
      edge_r   <= s_edge;
      keep_r   <= s_keep;
      da_r     <= DW'(s_a1) - DW'(s_a0);
      db_r     <= DW'(s_edge) - DW'(s_b0);
      den_r    <= DW'(s_b1) - DW'(s_b0);
    end
    if (cmd.mul) begin
      prod_r <= da_r * db_r;
    end
    if (cmd.div_init) begin
      dvd_r <= pmag;
      dvs_r <= dmag;
      rem_r <= '0;
      neg_r <= prod_r[PW-1] ^ den_r[DW-1];
    end
    if (cmd.div_step) begin
      if (!trial[DW]) begin
        rem_r <= trial[DW-1:0];
        dvd_r <= {dvd_r[PW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        dvd_r <= {dvd_r[PW-2:0], 1'b0};
      end
    end
    if (cmd.update) begin
      if (mv0_r) begin
        x0_r <= axis_x_r ? edge_r : new_c;
        y0_r <= axis_x_r ? new_c : edge_r;
      end else begin
        x1_r <= axis_x_r ? edge_r : new_c;
        y1_r <= axis_x_r ? new_c : edge_r;
      end
    end
    if (cmd.emit) begin
      if (cmd.emit_vis) begin
        res_r <= '{1'b1, x0_r, y0_r, x1_r, y1_r};
      end else begin
        res_r <= '0;
      end
    end
  end

  assign out_result = res_r;

endmodule

// ----- hdl/lswc_ctrl.sv -----
// Controller: sequences evaluation, multiply, divide and update per request.
`timescale 1ns / 1ps
module lswc_ctrl
  import lswc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dp_sts_t sts,
  output logic    busy,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic [MVW-1:0]  moves_r, moves_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            last_move;

  assign last_move = (moves_r >= MVW'(MAX_MOVES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      moves_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      moves_r <= moves_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (sts.cls == CLS_MOVE && !last_move) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL:  state_nxt = sts.den_zero ? ST_UPD : ST_DIVP;
      ST_DIVP: state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == CNTW'(1)) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_EVAL;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    moves_nxt = moves_r;
    cnt_nxt   = cnt_r;
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
    unique case (state_r)
      ST_IDLE: begin
        cmd.load  = start;
        moves_nxt = '0;
      end
      ST_EVAL: begin
        if (sts.cls == CLS_MOVE && !last_move) begin
          cmd.setup = 1'b1;
          moves_nxt = moves_r + MVW'(1);
        end else begin
          cmd.emit     = 1'b1;
          cmd.emit_vis = (sts.cls == CLS_ACCEPT);
        end
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_DIVP: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = CNTW'(PW);
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - CNTW'(1);
      end
      ST_UPD:  cmd.update = 1'b1;
      ST_DONE: ;
      default: ;
    endcase
  end

endmodule

// ----- hdl/line_segment_window_clipper.sv -----
// Top level of the Cohen-Sutherland line segment window clipper.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; busy stays high until the
// result has been shown. The result appears on out_result for exactly one cycle with
// out_valid high, and the receiver cannot hold it off. A segment fully inside the
// window goes from evaluation straight to the strobe; each edge move runs setup,
// multiply, divider load, 26 one-bit steps of the shared restoring divider and the
// endpoint update, and a request makes at most four moves. A new request is taken
// only once the block is back in idle. The user must write the window registers
// through cfg_we, cfg_index and cfg_data only while busy is low; the block does not
// enforce this. Rejected segments report visible low with all coordinates zero.
module line_segment_window_clipper
  import lswc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_result,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  coord_t    cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller issues one command group per cycle; the datapath reports
  // the outcode classification of the current endpoints.
  lswc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lswc_datapath u_dp (
    .clk        (clk),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .sts        (sts),
    .out_result (out_result)
  );

endmodule

// ----- hdl/lswc_checker.sv -----
// Port-level checks for the line segment window clipper, bound to the top level.
`timescale 1ns / 1ps
module lswc_checker
  import lswc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request accepted without busy");

  a_strobe_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a request");

  a_strobe_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid)) else $error("request did not end after result");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result.visible) |-> (out_result == '0))
    else $error("rejected result carries coordinates");

endmodule

bind line_segment_window_clipper lswc_checker u_lswc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_result (out_result)
);
